/* rtl/core/lpp_tfe_pkg.sv */
// ----------------------------------------------------------------------------
// lpp_tfe_pkg
// Shared types, constants and the type-length table for the telemetry
// field extractor.
// ----------------------------------------------------------------------------
package lpp_tfe_pkg;

  // Record types that carry a value the block keeps.
  localparam logic [7:0]  TYPE_TEMPERATURE = 8'd103;
  localparam logic [7:0]  TYPE_VOLTAGE     = 8'd116;

  // Temperature reported when no temperature record was seen.
  localparam logic [15:0] TEMP_ABSENT      = 16'h7FFF;

  // Position of the walk inside the record chain.
  typedef enum logic [1:0] {
    PH_CHAN  = 2'd0,
    PH_TYPE  = 2'd1,
    PH_VALUE = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  // One payload beat as it enters the walker.
  typedef struct packed {
    logic       take;
    logic [7:0] data;
    logic       present;
    logic       last;
  } beat_t;

  // Held values after the current beat has been applied.
  typedef struct packed {
    logic [15:0] battery;
    logic [15:0] temp;
  } result_t;

  // Value length of a known record type; zero marks an unknown type.
  function automatic logic [3:0] value_length(input logic [7:0] t);
    logic [3:0] len;
    unique case (t)
      8'd0, 8'd1, 8'd102, 8'd104, 8'd120, 8'd142: len = 4'd1;
      8'd2, 8'd3, 8'd101, 8'd103, 8'd115, 8'd116,
      8'd117, 8'd121, 8'd125, 8'd128:              len = 4'd2;
      8'd118, 8'd134:                              len = 4'd4;
      8'd113:                                      len = 4'd6;
      8'd136:                                      len = 4'd9;
      default:                                     len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

/* rtl/core/lpp_tfe_walker.sv */
// ----------------------------------------------------------------------------
// lpp_tfe_walker
// Record walker: tracks the channel/type/value layout, keeps the latest
// battery and temperature values, and clears itself after the final beat.
// ----------------------------------------------------------------------------
module lpp_tfe_walker (
  input  logic                 clk,
  input  logic                 rst,
  input  lpp_tfe_pkg::beat_t   beat,
  output lpp_tfe_pkg::result_t result
);

  lpp_tfe_pkg::phase_t phase, phase_next;
  logic [3:0]  bytes_left, bytes_left_next;
  logic [7:0]  record_type, record_type_next;
  logic [7:0]  high_value_byte, high_value_byte_next;
  logic [15:0] battery_hold, battery_hold_next;
  logic [15:0] temp_hold, temp_hold_next;

  logic        use_byte;
  logic [3:0]  len;
  logic        value_end;
  logic [15:0] value_word;
  logic [15:0] value_times_ten;

  assign use_byte        = beat.take & beat.present;
  assign len             = lpp_tfe_pkg::value_length(beat.data);
  assign value_end       = use_byte && (phase == lpp_tfe_pkg::PH_VALUE) && (bytes_left <= 4'd1);
  assign value_word      = {high_value_byte, beat.data};
  // Times ten as 8x + 2x, kept to 16 bits.
  assign value_times_ten = {value_word[12:0], 3'b000} + {value_word[14:0], 1'b0};

  // Next state of the walk.
  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    if (use_byte) begin
      unique case (phase)
        lpp_tfe_pkg::PH_CHAN: begin
          phase_next = lpp_tfe_pkg::PH_TYPE;
        end
        lpp_tfe_pkg::PH_TYPE: begin
          if (len == 4'd0) begin
            phase_next = lpp_tfe_pkg::PH_STOP;
          end else begin
            bytes_left_next = len;
            phase_next      = lpp_tfe_pkg::PH_VALUE;
          end
        end
        lpp_tfe_pkg::PH_VALUE: begin
          if (bytes_left <= 4'd1) begin
            bytes_left_next = 4'd0;
            phase_next      = lpp_tfe_pkg::PH_CHAN;
          end else begin
            bytes_left_next = bytes_left - 4'd1;
          end
        end
        lpp_tfe_pkg::PH_STOP: begin
          phase_next = lpp_tfe_pkg::PH_STOP;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // Datapath updates that follow the walk.
  always_comb begin
    record_type_next     = record_type;
    high_value_byte_next = high_value_byte;
    battery_hold_next    = battery_hold;
    temp_hold_next       = temp_hold;
    if (use_byte && (phase == lpp_tfe_pkg::PH_TYPE) && (len != 4'd0)) begin
      record_type_next = beat.data;
    end
    if (use_byte && (phase == lpp_tfe_pkg::PH_VALUE)) begin
      high_value_byte_next = beat.data;
    end
    if (value_end && (record_type == lpp_tfe_pkg::TYPE_VOLTAGE)) begin
      battery_hold_next = value_times_ten;
    end
    if (value_end && (record_type == lpp_tfe_pkg::TYPE_TEMPERATURE)) begin
      temp_hold_next = value_word;
    end
  end

  // The result reflects the beat just applied, ahead of the end-of-payload clear.
  assign result.battery = battery_hold_next;
  assign result.temp    = temp_hold_next;

  always_ff @(posedge clk) begin
    if (rst || (beat.take && beat.last)) begin
      phase           <= lpp_tfe_pkg::PH_CHAN;
      bytes_left      <= 4'd0;
      record_type     <= 8'd0;
      high_value_byte <= 8'd0;
      battery_hold    <= 16'd0;
      temp_hold       <= lpp_tfe_pkg::TEMP_ABSENT;
    end else begin
      phase           <= phase_next;
      bytes_left      <= bytes_left_next;
      record_type     <= record_type_next;
      high_value_byte <= high_value_byte_next;
      battery_hold    <= battery_hold_next;
      temp_hold       <= temp_hold_next;
    end
  end

endmodule

/* rtl/core/lpp_telemetry_field_extractor_unit.sv */
// ----------------------------------------------------------------------------
// lpp_telemetry_field_extractor_unit
// Walks a telemetry payload one byte per beat and reports the last battery
// voltage and temperature found when the payload ends.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake          | Payload
//  --------+--------------------+-----------------------------------------
//  in      | in_valid/in_stall  | data_byte, byte_present, last_byte
//  out     | out_valid/out_stall| battery_mv, temp_decideg
//
// One input beat is taken every cycle while in_stall is low. A beat is
// captured in an input register, then walked through the record decoder
// and, on the final beat, written to the result register.
// Reset (rst, synchronous) empties both registers and returns the walker to
// the start of a record with no held values. Input is stalled only when a
// final beat sits in the input register while a previous result is still
// waiting downstream; other beats keep flowing under an output stall.
//
module lpp_telemetry_field_extractor_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               byte_present,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        battery_mv,
  output logic signed [15:0] temp_decideg
);

  // Input register stage.
  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_present;
  logic       s1_last;

  // A final beat cannot move on while the result register is occupied and
  // held by the downstream side.
  logic s1_hold;

  lpp_tfe_pkg::beat_t   beat;
  lpp_tfe_pkg::result_t result;

  assign s1_hold  = s1_valid & s1_last & out_valid & out_stall;
  assign in_stall = s1_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_hold) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!s1_hold && in_valid) begin
      s1_data    <= data_byte;
      s1_present <= byte_present;
      s1_last    <= last_byte;
    end
  end

  assign beat.take    = s1_valid & ~s1_hold;
  assign beat.data    = s1_data;
  assign beat.present = s1_present;
  assign beat.last    = s1_last;

  lpp_tfe_walker u_walker (
    .clk    (clk),
    .rst    (rst),
    .beat   (beat),
    .result (result)
  );

  // Result register: loaded by each final beat, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (beat.take && beat.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat.take && beat.last) begin
      battery_mv   <= result.battery;
      temp_decideg <= $signed(result.temp);
    end
  end

endmodule
